// File: src/rpr_pkg.sv
// Shared types and constants for the relocation patch resolver.
package rpr_pkg;

	localparam int LABEL_SLOTS = 64;
	localparam int CNT_W = $clog2(LABEL_SLOTS + 1);
	localparam int IDX_W = (LABEL_SLOTS > 1) ? $clog2(LABEL_SLOTS) : 1;

	localparam logic [1:0] CMD_CLEAR = 2'd0;
	localparam logic [1:0] CMD_LOAD  = 2'd1;
	localparam logic [1:0] CMD_APPLY = 2'd2;

	localparam logic [1:0] STATUS_OK        = 2'd0;
	localparam logic [1:0] STATUS_UNDEFINED = 2'd1;
	localparam logic [1:0] STATUS_NO_CODE   = 2'd2;

	localparam logic CFG_CODE_SIZE  = 1'b0;
	localparam logic CFG_BASE_VADDR = 1'b1;

	localparam logic [31:0] REL_BIAS   = 32'd4;
	localparam logic [32:0] EIGHT_SPAN = 33'd7;

	localparam logic [3:0] BYTES_NONE  = 4'd0;
	localparam logic [3:0] BYTES_FOUR  = 4'd4;
	localparam logic [3:0] BYTES_EIGHT = 4'd8;

	typedef struct packed {
		logic [1:0]  cmd;
		logic [31:0] label_key;
		logic [31:0] label_offset;
		logic [31:0] patch_pos;
		logic        pc_rel;
	} item_t;

	typedef struct packed {
		logic [31:0] patch_address;
		logic [63:0] patch_value;
		logic [3:0]  byte_count;
		logic [1:0]  status;
	} result_t;

	// Search token handed from cell to cell
	typedef struct packed {
		logic        active;
		logic        found;
		logic [31:0] key;
		logic [31:0] offset;
	} tok_t;

endpackage

// File: src/relocation_patch_resolver_top.sv
// Top level of the relocation patch resolver: label chain, control and result register.
//
// Clear and load transactions complete without leaving the idle state. An apply transaction
// sends a search token down a chain of LABEL_SLOTS cells, one cell per cycle; the match is
// captured as the token leaves the last cell, and the patch is formed in the calc state and
// registered once the output register is free, before the block takes the next item. The result
// sits in an output register, so a new item is accepted while it waits to be taken.
module relocation_patch_resolver_top import rpr_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_we,
	input  logic        cfg_index,
	input  logic [63:0] cfg_wdata,
	input  logic        item_valid,
	output logic        item_ready,
	input  item_t       item,
	output logic        result_valid,
	input  logic        result_ready,
	output result_t     result
);

	typedef enum logic [2:0] {
		S_IDLE   = 3'b001,
		S_SEARCH = 3'b010,
		S_CALC   = 3'b100
	} state_t;

	state_t            state_q;
	logic [31:0]       code_size_q;
	logic [63:0]       base_vaddr_q;
	logic [CNT_W-1:0]  count_q;
	logic [31:0]       poff_q;
	logic              rel_q;
	logic              found_q;
	logic [31:0]       target_q;
	logic              result_valid_q;
	result_t           result_q;

	logic                   accept;
	logic                   do_load;
	tok_t                   chain [0:LABEL_SLOTS];
	logic [LABEL_SLOTS-1:0] live;
	logic [LABEL_SLOTS-1:0] wr_sel;
	logic [LABEL_SLOTS-1:0] tok_act;
	logic                   out_free;
	result_t                calc;
	logic [31:0]            rel_val;
	logic                   fits8;

	assign item_ready = (state_q == S_IDLE);
	assign accept     = item_valid && item_ready;
	assign do_load    = accept && (item.cmd == CMD_LOAD) && (count_q < CNT_W'(LABEL_SLOTS));

	assign chain[0] = '{active: accept && (item.cmd == CMD_APPLY), found: 1'b0,
		key: item.label_key, offset: 32'd0};

	for (genvar i = 0; i < LABEL_SLOTS; i++) begin : g_cell
		assign live[i]    = CNT_W'(i) < count_q;
		assign wr_sel[i]  = do_load && (count_q[IDX_W-1:0] == IDX_W'(i));
		assign tok_act[i] = chain[i+1].active;
		rpr_cell u_cell (
			.clk       (clk),
			.arst_n    (arst_n),
			.wr_en     (wr_sel[i]),
			.wr_key    (item.label_key),
			.wr_offset (item.label_offset),
			.live      (live[i]),
			.tok_in    (chain[i]),
			.tok_out   (chain[i+1])
		);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			code_size_q  <= '0;
			base_vaddr_q <= '0;
		end else if (cfg_we) begin
			case (cfg_index)
				CFG_CODE_SIZE:  code_size_q  <= cfg_wdata[31:0];
				CFG_BASE_VADDR: base_vaddr_q <= cfg_wdata;
				default:        ;
			endcase
		end
	end

	// patch formation from the captured match
	always_comb begin
		rel_val = target_q - (poff_q + REL_BIAS);
		fits8   = ({1'b0, poff_q} + EIGHT_SPAN) < {1'b0, code_size_q};
		calc.patch_address = poff_q;
		calc.patch_value   = 64'd0;
		calc.byte_count    = BYTES_NONE;
		if (code_size_q == 32'd0) begin
			calc.status = STATUS_NO_CODE;
		end else if (!found_q) begin
			calc.status = STATUS_UNDEFINED;
		end else begin
			calc.status = STATUS_OK;
			if (rel_q) begin
				calc.patch_value = {32'd0, rel_val};
				calc.byte_count  = BYTES_FOUR;
			end else begin
				calc.patch_value = base_vaddr_q + {32'd0, target_q};
				calc.byte_count  = fits8 ? BYTES_EIGHT : BYTES_FOUR;
			end
		end
	end

	assign out_free = !result_valid_q || result_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q        <= S_IDLE;
			count_q        <= '0;
			result_valid_q <= 1'b0;
		end else begin
			if (state_q == S_CALC && out_free) begin
				result_valid_q <= 1'b1;
			end else if (result_valid_q && result_ready) begin
				result_valid_q <= 1'b0;
			end
			case (state_q)
				S_IDLE: begin
					if (accept) begin
						case (item.cmd)
							CMD_CLEAR: count_q <= '0;
							CMD_LOAD:  if (do_load) count_q <= count_q + 1'b1;
							CMD_APPLY: state_q <= S_SEARCH;
							default:   ;
						endcase
					end
				end
				S_SEARCH: begin
					if (chain[LABEL_SLOTS].active) begin
						state_q <= S_CALC;
					end
				end
				S_CALC: begin
					if (out_free) begin
						state_q <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			poff_q <= item.patch_pos;
			rel_q  <= item.pc_rel;
		end
		if (state_q == S_SEARCH && chain[LABEL_SLOTS].active) begin
			found_q  <= chain[LABEL_SLOTS].found;
			target_q <= chain[LABEL_SLOTS].offset;
		end
		if (state_q == S_CALC && out_free) begin
			result_q <= calc;
		end
	end

	assign result_valid = result_valid_q;
	assign result       = result_q;

`ifndef SYNTHESIS
	a_one_token: assert property (@(posedge clk) disable iff (!arst_n) $onehot0(tok_act))
		else $error("more than one search token in the chain");

	a_idle_chain_empty: assert property (@(posedge clk) disable iff (!arst_n)
		item_ready |-> (tok_act == '0))
		else $error("block ready while a search is in flight");

	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CNT_W'(LABEL_SLOTS))
		else $error("entry count beyond capacity");

	a_bytes_status: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid |-> ((result.status == STATUS_OK) == (result.byte_count != BYTES_NONE)))
		else $error("byte count disagrees with status");

	a_search_to_calc: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_SEARCH && chain[LABEL_SLOTS].active) |=> (state_q == S_CALC))
		else $error("search end not captured");
`endif

endmodule

// File: src/rpr_cell.sv
// One label slot of the search chain: holds a pair and matches the passing token.
module rpr_cell import rpr_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        wr_en,
	input  logic [31:0] wr_key,
	input  logic [31:0] wr_offset,
	input  logic        live,
	input  tok_t        tok_in,
	output tok_t        tok_out
);

	logic [31:0] key_q;
	logic [31:0] offset_q;
	logic        active_q;
	logic        found_q;
	logic [31:0] tkey_q;
	logic [31:0] toffset_q;
	logic        hit;

	always_ff @(posedge clk) begin
		if (wr_en) begin
			key_q    <= wr_key;
			offset_q <= wr_offset;
		end
	end

	// earlier cells already matched: keep their offset
	assign hit = tok_in.active && !tok_in.found && live && (key_q == tok_in.key);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			active_q <= 1'b0;
		end else begin
			active_q <= tok_in.active;
		end
	end

	always_ff @(posedge clk) begin
		found_q   <= tok_in.found | hit;
		tkey_q    <= tok_in.key;
		toffset_q <= hit ? offset_q : tok_in.offset;
	end

	assign tok_out = '{active: active_q, found: found_q, key: tkey_q, offset: toffset_q};

endmodule

// File: test/relocation_patch_resolver_top_tb.sv
// Testbench for the relocation patch resolver: random traffic checked against a predictor.
module relocation_patch_resolver_top_tb;
	import rpr_pkg::*;

	localparam int STALL_LIMIT = 3000;
	localparam int DRAIN_CYCLES = LABEL_SLOTS + 8;
	localparam int ITEM_TARGET = 2000;
	localparam logic [1:0] CMD_UNUSED = 2'd3;

	logic        clk = 1'b0;
	logic        arst_n;
	logic        cfg_we;
	logic        cfg_index;
	logic [63:0] cfg_wdata;
	logic        item_valid = 1'b0;
	logic        item_ready;
	item_t       item = '0;
	logic        result_valid;
	logic        result_ready = 1'b0;
	result_t     result;

	relocation_patch_resolver_top uut (
		.clk(clk),
		.arst_n(arst_n),
		.cfg_we(cfg_we),
		.cfg_index(cfg_index),
		.cfg_wdata(cfg_wdata),
		.item_valid(item_valid),
		.item_ready(item_ready),
		.item(item),
		.result_valid(result_valid),
		.result_ready(result_ready),
		.result(result)
	);

	always #4 clk = ~clk;

	// Predictor state: label table and register copies
	logic [31:0] label_keys [LABEL_SLOTS];
	logic [31:0] label_offs [LABEL_SLOTS];
	int          table_fill = 0;
	logic [31:0] model_code_size = '0;
	logic [63:0] model_base = '0;

	item_t   pending_items [$];
	result_t patch_expect [$];
	int      mismatches = 0;
	int      idle_cycles = 0;
	int      items_queued = 0;
	bit      no_idle = 1'b0;

	int send_gap = 0;
	int stall_left = 0;
	int ready_roll;

	function automatic int pick_gap();
		int r;
		r = $urandom_range(0, 99);
		if (no_idle || r < 60)
			return 0;
		if (r < 92)
			return $urandom_range(1, 3);
		return $urandom_range(10, 60);
	endfunction

	function automatic void resolve_item(item_t it);
		result_t r;
		logic [31:0] target;
		bit found;
		found = 1'b0;
		target = '0;
		case (it.cmd)
			CMD_CLEAR: table_fill = 0;
			CMD_LOAD: begin
				if (table_fill < LABEL_SLOTS) begin
					label_keys[table_fill] = it.label_key;
					label_offs[table_fill] = it.label_offset;
					table_fill++;
				end
			end
			CMD_APPLY: begin
				r.patch_address = it.patch_pos;
				r.patch_value = '0;
				r.byte_count = BYTES_NONE;
				// earliest loaded match wins
				for (int i = 0; i < table_fill; i++)
					if (!found && label_keys[i] == it.label_key) begin
						found = 1'b1;
						target = label_offs[i];
					end
				if (model_code_size == '0)
					r.status = STATUS_NO_CODE;
				else if (!found)
					r.status = STATUS_UNDEFINED;
				else begin
					r.status = STATUS_OK;
					if (it.pc_rel) begin
						r.patch_value = {32'h0, target - (it.patch_pos + REL_BIAS)};
						r.byte_count = BYTES_FOUR;
					end else begin
						r.patch_value = model_base + {32'h0, target};
						// 33-bit sum, no wrap
						r.byte_count = ({1'b0, it.patch_pos} + EIGHT_SPAN <
							{1'b0, model_code_size}) ? BYTES_EIGHT : BYTES_FOUR;
					end
				end
				patch_expect.push_back(r);
			end
			default: ;
		endcase
	endfunction

	function automatic void check_field(string name, logic [63:0] want, logic [63:0] got);
		if (got !== want) begin
			$display("%0t: %s expected %h got %h", $time, name, want, got);
			mismatches++;
		end
	endfunction

	// Driver: one pending transaction at a time, random gaps between them
	always @(posedge clk) begin
		if (arst_n && (!item_valid || item_ready)) begin
			if (send_gap > 0 || pending_items.size() == 0) begin
				item_valid <= 1'b0;
				if (send_gap > 0)
					send_gap <= send_gap - 1;
			end else begin
				item_valid <= 1'b1;
				item <= pending_items.pop_front();
				send_gap <= pick_gap();
			end
		end
	end

	// Result side back-pressure
	always @(posedge clk) begin
		if (arst_n) begin
			if (stall_left > 0) begin
				result_ready <= 1'b0;
				stall_left <= stall_left - 1;
			end else if (no_idle) begin
				result_ready <= 1'b1;
			end else begin
				ready_roll = $urandom_range(0, 99);
				if (ready_roll < 70) begin
					result_ready <= 1'b1;
				end else begin
					result_ready <= 1'b0;
					stall_left <= (ready_roll < 95) ? $urandom_range(0, 3)
						: $urandom_range(10, 60);
				end
			end
		end
	end

	// Monitor: check result against oldest expectation, then predict the new transaction
	always @(posedge clk) begin
		if (arst_n) begin
			if (result_valid && result_ready) begin
				if (patch_expect.size() == 0) begin
					$display("%0t: unexpected result expected none got %h", $time, result);
					mismatches++;
				end else begin
					result_t want;
					want = patch_expect.pop_front();
					check_field("patch_address", 64'(want.patch_address),
						64'(result.patch_address));
					check_field("patch_value", want.patch_value, result.patch_value);
					check_field("byte_count", 64'(want.byte_count), 64'(result.byte_count));
					check_field("status", 64'(want.status), 64'(result.status));
				end
			end
			if (item_valid && item_ready)
				resolve_item(item);
		end
	end

	always @(posedge clk) begin
		if (arst_n) begin
			if ((item_valid && item_ready) || (result_valid && result_ready) || cfg_we)
				idle_cycles <= 0;
			else
				idle_cycles <= idle_cycles + 1;
			if (idle_cycles >= STALL_LIMIT) begin
				$display("%0t: no transaction for %0d cycles", $time, idle_cycles);
				$display("TEST FAILED");
				$finish;
			end
		end
	end

	task automatic queue_item(logic [1:0] cmd, logic [31:0] key, logic [31:0] loff,
			logic [31:0] poff, logic rel);
		item_t it;
		it.cmd = cmd;
		it.label_key = key;
		it.label_offset = loff;
		it.patch_pos = poff;
		it.pc_rel = rel;
		pending_items.push_back(it);
		if (cmd != CMD_UNUSED)
			items_queued++;
	endtask

	// Block the sender until all results are back and the apply chain has emptied
	task automatic wait_idle();
		while (pending_items.size() != 0 || item_valid || patch_expect.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	task automatic write_reg(logic idx, logic [63:0] val);
		@(posedge clk);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_wdata <= val;
		@(posedge clk);
		cfg_we <= 1'b0;
		if (idx == CFG_CODE_SIZE)
			model_code_size = val[31:0];
		else
			model_base = val;
	endtask

	function automatic logic [31:0] rand_key();
		int r;
		r = $urandom_range(0, 99);
		if (r < 25)
			return $urandom_range(0, 7);
		if (r < 28)
			return '0;
		if (r < 31)
			return '1;
		return $urandom();
	endfunction

	function automatic logic [31:0] rand_poff();
		case ($urandom_range(0, 3))
			0: return $urandom();
			1: return model_code_size - $urandom_range(0, 12);
			2: return $urandom_range(0, 64);
			default: return 32'hFFFF_FFFF - $urandom_range(0, 8);
		endcase
	endfunction

	initial begin
		logic [31:0] key_pool [$];
		logic [31:0] k;
		logic [31:0] loff;
		logic [63:0] v;
		int n;
		int r;

		cfg_we = 1'b0;
		cfg_index = CFG_CODE_SIZE;
		cfg_wdata = '0;
		arst_n = 1'b0;
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;

		// code size zero after reset wins over a missing label
		queue_item(CMD_APPLY, 32'h0, 32'h0, 32'h0, 1'b1);
		queue_item(CMD_LOAD, 32'd5, 32'd100, 32'h0, 1'b0);
		queue_item(CMD_APPLY, 32'd5, 32'h0, 32'd3, 1'b0);
		wait_idle();
		write_reg(CFG_CODE_SIZE, 64'd16);
		write_reg(CFG_BASE_VADDR, '1);
		queue_item(CMD_LOAD, 32'd5, 32'd200, '1, 1'b1);
		queue_item(CMD_LOAD, '1, '1, 32'h0, 1'b0);
		queue_item(CMD_LOAD, 32'h0, 32'h0, 32'h0, 1'b0);
		queue_item(CMD_APPLY, 32'd5, '1, 32'h0, 1'b1);
		queue_item(CMD_APPLY, 32'd5, 32'h0, 32'd200, 1'b1);
		queue_item(CMD_APPLY, '1, 32'h0, 32'd8, 1'b0);
		queue_item(CMD_APPLY, '1, 32'h0, 32'd9, 1'b0);
		queue_item(CMD_APPLY, 32'h0, 32'h0, '1, 1'b0);
		queue_item(CMD_APPLY, 32'h0, 32'h0, '1, 1'b1);
		queue_item(CMD_APPLY, 32'h1234, 32'h0, 32'd4, 1'b0);
		queue_item(CMD_UNUSED, '1, '1, '1, 1'b1);
		queue_item(CMD_CLEAR, '1, '1, '1, 1'b1);
		queue_item(CMD_APPLY, 32'd5, 32'h0, 32'h0, 1'b1);
		wait_idle();
		write_reg(CFG_CODE_SIZE, 64'hFFFF_FFFF);
		write_reg(CFG_BASE_VADDR, 64'h0);
		queue_item(CMD_LOAD, 32'd9, 32'h8000_0000, 32'h0, 1'b0);
		queue_item(CMD_APPLY, 32'd9, 32'h0, 32'hFFFF_FFF7, 1'b0);
		queue_item(CMD_APPLY, 32'd9, 32'h0, 32'hFFFF_FFF8, 1'b0);

		while (items_queued < ITEM_TARGET) begin
			wait_idle();
			no_idle = ($urandom_range(0, 3) == 0);
			case ($urandom_range(0, 9))
				0: v = 64'h0;
				1: v = 64'd1;
				2: v = 64'd8;
				3: v = 64'hFFFF_FFFF;
				4, 5, 6: v = 64'($urandom_range(1, 256));
				default: v = {32'h0, $urandom()};
			endcase
			if ($urandom_range(0, 3) != 0)
				write_reg(CFG_CODE_SIZE, v);
			case ($urandom_range(0, 3))
				0: v = 64'h0;
				1: v = '1;
				default: v = {$urandom(), $urandom()};
			endcase
			if ($urandom_range(0, 3) != 0)
				write_reg(CFG_BASE_VADDR, v);

			if ($urandom_range(0, 9) < 7) begin
				queue_item(CMD_CLEAR, $urandom(), $urandom(), $urandom(), 1'($urandom()));
				key_pool.delete();
			end
			// now and then overfill the table so loads get dropped
			n = ($urandom_range(0, 3) == 0) ? $urandom_range(60, 75) : $urandom_range(0, 20);
			repeat (n) begin
				k = rand_key();
				r = $urandom_range(0, 9);
				loff = (r == 0) ? 32'h0 : (r == 1) ? '1 : $urandom();
				queue_item(CMD_LOAD, k, loff, $urandom(), 1'($urandom()));
				key_pool.push_back(k);
			end
			repeat ($urandom_range(20, 80)) begin
				r = $urandom_range(0, 99);
				if (r < 60) begin
					k = (key_pool.size() != 0)
						? key_pool[$urandom_range(0, key_pool.size() - 1)] : rand_key();
					queue_item(CMD_APPLY, k, $urandom(), rand_poff(), 1'($urandom()));
				end else if (r < 85) begin
					k = rand_key();
					queue_item(CMD_LOAD, k, $urandom(), $urandom(), 1'($urandom()));
					key_pool.push_back(k);
				end else if (r < 90) begin
					queue_item(CMD_CLEAR, $urandom(), $urandom(), $urandom(),
						1'($urandom()));
					key_pool.delete();
				end else if (r < 95) begin
					queue_item(CMD_UNUSED, $urandom(), $urandom(), $urandom(),
						1'($urandom()));
				end else begin
					queue_item(CMD_APPLY, $urandom(), $urandom(), rand_poff(),
						1'($urandom()));
				end
			end
		end

		wait_idle();
		if (mismatches == 0)
			$display("TEST PASSED");
		else
			$display("TEST FAILED");
		$finish;
	end

endmodule

// File: filelist.f
src/rpr_pkg.sv
src/rpr_cell.sv
src/relocation_patch_resolver_top.sv
test/relocation_patch_resolver_top_tb.sv
